// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the rank decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RKRD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error(msg);

// A condition that must never be true at a clock edge outside reset.
`define RKRD_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error(msg);

`endif

// ----- hdl/rkrd_pkg.sv -----
package rkrd_pkg;

  // Default capacity of the key memory.
  localparam int unsigned MaxKeysDef = 64;

  localparam int unsigned KeyW  = 32;
  localparam int unsigned PosW  = 6;
  localparam int unsigned RankW = 6;

  // Ranking sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_CAPT,
    ST_SWEEP,
    ST_EMIT
  } state_e;

  // One input item.
  typedef struct packed {
    logic signed [KeyW-1:0] key_value;
    logic                   is_last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [PosW-1:0]  position;
    logic [RankW-1:0] rank;
    logic             run_end;
    logic             overflowed;
  } out_item_t;

  // Control from the sequencer to the compare and count unit.
  typedef struct packed {
    logic            load_pivot;
    logic            cmp_en;
    logic [PosW-1:0] cmp_pos;
    logic [PosW-1:0] pivot_pos;
  } rank_ctl_t;

endpackage

// ----- hdl/random_key_rank_decoder.sv -----
// Random-key rank decoder.
// Input channel (in_valid_i / in_stall_o): one signed Q16.16 key per transfer,
// stored in arrival order. The transfer with is_last set closes the set.
// Keys beyond MaxKeys are dropped and flag every result of that set.
// Output channel (out_valid_o / out_stall_i): once a set closes, one result
// per stored position in position order, carrying the key's rank, the
// overflow flag and run_end on the last position.
// Configuration (cfg_valid_i / cfg_ready_o): writes the descending bit; it
// is always ready and should only be written between sets.
// Keys load at one per cycle while no set is being ranked. Ranking a set
// of n keys reads the key memory once per compare through its single read
// port: each result goes through a pivot read, a pivot capture, one compare
// per stored key and a result hand-off, and input is stalled until the set is done.
// A stalled output holds its result and the sequencer waits on it.
// Reset empties the set, clears the overflow flag and selects ascending
// order; the key memory needs no clearing, only written entries are read.
`include "assert_macros.svh"

module random_key_rank_decoder #(
  parameter int unsigned MaxKeys = rkrd_pkg::MaxKeysDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rkrd_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rkrd_pkg::out_item_t out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxKeys);
  localparam int unsigned CW = $clog2(MaxKeys + 1);

  rkrd_pkg::state_e state_q, state_d;

  logic [CW-1:0]                    cnt_q, cnt_d;
  logic                             ovf_q, ovf_d;
  logic [AW-1:0]                    p_q, p_d;
  logic [CW-1:0]                    ja_q, ja_d;
  logic                             cmp_vld_q, cmp_vld_d;
  logic [AW-1:0]                    cmp_idx_q, cmp_idx_d;
  logic                             desc_q;
  logic                             out_vld_q, out_vld_d;
  rkrd_pkg::out_item_t              out_q;

  logic [rkrd_pkg::KeyW-1:0]        key_mem_q [MaxKeys];
  logic signed [rkrd_pkg::KeyW-1:0] rdata_q;
  logic [AW-1:0]                    raddr;
  logic                             wr_en;

  logic                             in_fire;
  logic                             full;
  logic                             last_p;
  logic                             sweep_done;
  logic                             slot_free;
  logic                             emit_fire;
  rkrd_pkg::rank_ctl_t              ctl;
  logic [rkrd_pkg::RankW-1:0]       rank;

  assign in_fire    = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CW'(MaxKeys));
  assign last_p     = ((CW'(p_q) + CW'(1)) == cnt_q);
  assign sweep_done = cmp_vld_q && ((CW'(cmp_idx_q) + CW'(1)) == cnt_q);
  assign slot_free  = !out_vld_q || !out_stall_i;
  assign emit_fire  = (state_q == rkrd_pkg::ST_EMIT) && slot_free;
  assign wr_en      = in_fire && !full;

  // Sequencer: load keys, then per position read the pivot, sweep and emit.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    p_d       = p_q;
    ja_d      = ja_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    raddr     = p_q;
    in_stall_o = 1'b1;
    ctl.load_pivot = 1'b0;
    ctl.cmp_en     = 1'b0;
    ctl.cmp_pos    = rkrd_pkg::PosW'(cmp_idx_q);
    ctl.pivot_pos  = rkrd_pkg::PosW'(p_q);
    unique case (state_q)
      rkrd_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_fire) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            cnt_d = cnt_q + CW'(1);
          end
          if (in_item_i.is_last) begin
            p_d     = '0;
            state_d = rkrd_pkg::ST_PIVOT;
          end
        end
      end
      rkrd_pkg::ST_PIVOT: begin
        raddr   = p_q;
        state_d = rkrd_pkg::ST_CAPT;
      end
      rkrd_pkg::ST_CAPT: begin
        ctl.load_pivot = 1'b1;
        raddr     = '0;
        ja_d      = CW'(1);
        cmp_vld_d = 1'b1;
        cmp_idx_d = '0;
        state_d   = rkrd_pkg::ST_SWEEP;
      end
      rkrd_pkg::ST_SWEEP: begin
        ctl.cmp_en = cmp_vld_q;
        raddr      = ja_q[AW-1:0];
        if (ja_q < cnt_q) begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = ja_q[AW-1:0];
          ja_d      = ja_q + CW'(1);
        end
        if (sweep_done) begin
          cmp_vld_d = 1'b0;
          state_d   = rkrd_pkg::ST_EMIT;
        end
      end
      rkrd_pkg::ST_EMIT: begin
        if (slot_free) begin
          if (last_p) begin
            cnt_d   = '0;
            ovf_d   = 1'b0;
            state_d = rkrd_pkg::ST_IDLE;
          end else begin
            p_d     = p_q + AW'(1);
            state_d = rkrd_pkg::ST_PIVOT;
          end
        end
      end
      default: begin
        state_d = rkrd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rkrd_pkg::ST_IDLE;
      cnt_q     <= '0;
      ovf_q     <= 1'b0;
      p_q       <= '0;
      ja_q      <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
      desc_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      p_q       <= p_d;
      ja_q      <= ja_d;
      cmp_vld_q <= cmp_vld_d;
      cmp_idx_q <= cmp_idx_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        desc_q <= cfg_data_i;
      end
    end
  end

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem_q[cnt_q[AW-1:0]] <= in_item_i.key_value;
    end
    rdata_q <= key_mem_q[raddr];
  end

  rkrd_rank_unit u_rank_unit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .key_i        (rdata_q),
    .descending_i (desc_q),
    .rank_o       (rank)
  );

  // Output register, loaded when the previous result has been taken.
  always_comb begin
    out_vld_d = out_vld_q;
    if (emit_fire) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_q.position   <= rkrd_pkg::PosW'(p_q);
      out_q.rank       <= rank;
      out_q.run_end    <= last_p;
      out_q.overflowed <= ovf_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // Checks on the sequencer.
  `RKRD_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CW'(MaxKeys), "key count above capacity")
  `RKRD_NEVER(a_rank_range, clk_i, rst_ni, emit_fire && (CW'(rank) >= cnt_q), "rank not below set size")
  `RKRD_ASSERT(a_set_clear, clk_i, rst_ni, emit_fire && last_p |=> (cnt_q == '0) && !ovf_q, "set not cleared after last result")

endmodule

// ----- hdl/rkrd_rank_unit.sv -----
module rkrd_rank_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rkrd_pkg::rank_ctl_t              ctl_i,
  input  logic signed [rkrd_pkg::KeyW-1:0] key_i,
  input  logic                             descending_i,
  output logic [rkrd_pkg::RankW-1:0]       rank_o
);

  logic signed [rkrd_pkg::KeyW-1:0] pivot_q;
  logic [rkrd_pkg::PosW-1:0]        pivot_pos_q;
  logic [rkrd_pkg::RankW-1:0]       count_q, count_d;
  logic                             beats;

  // A stored key beats the pivot when it is strictly better in the chosen
  // direction, or equal and at a lower position.
  always_comb begin
    if (descending_i) begin
      beats = (key_i > pivot_q);
    end else begin
      beats = (key_i < pivot_q);
    end
    if ((key_i == pivot_q) && (ctl_i.cmp_pos < pivot_pos_q)) begin
      beats = 1'b1;
    end
  end

  // Count of keys that beat the pivot, cleared when a new pivot loads.
  always_comb begin
    count_d = count_q;
    if (ctl_i.load_pivot) begin
      count_d = '0;
    end else if (ctl_i.cmp_en && beats) begin
      count_d = count_q + rkrd_pkg::RankW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Pivot key and its position.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_pivot) begin
      pivot_q     <= key_i;
      pivot_pos_q <= ctl_i.pivot_pos;
    end
  end

  assign rank_o = count_q;

endmodule
